// ===== rtl/suis_pkg.sv =====
// Package for the sorted unique identifier set insert unit.
// Holds sizes, status codes, the controller state type and the cell control struct.
// No dependencies; every other file in rtl/ uses it.
package suis_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int ID_W = 64;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Widths of the result fields as seen on the ports.
   localparam int STATUS_W = 2;
   localparam int POS_W = 6;
   localparam int COUNT_W = 7;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // Broadcast control from the controller to every cell.
   typedef struct packed {
      logic            cmp_en;
      logic            ins_en;
      logic [ID_W-1:0] key;
   } cell_ctrl_type;

   // Summary of the cell flags returned to the controller.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] pos;
   } chain_flags_type;

endpackage

// ===== rtl/sorted_unique_id_set_insert_unit.sv =====
// Top level of the sorted unique identifier set insert unit.
// Controller, entry count and result ports around a chain of compare-and-shift cells.
// Depends on suis_pkg and suis_chain.
//
// Channel      Ports                                   Transfer
// request      start, busy, req_new_id                 start high while busy low
// response     rsp_strobe, rsp_status, rsp_was_new,    one cycle with rsp_strobe high
//              rsp_position, rsp_entry_count
//
// Each item passes through acceptance in the idle state, a compare state in which every
// cell compares its entry with the key, and an update state in which the cells shift and
// the result is shown. The compare-then-shift pass through the cell row sets this order.
// Reset clears the entry count and the controller; the entries need no clearing.
// The receiver cannot stall; the result appears for exactly one cycle.
module sorted_unique_id_set_insert_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [suis_pkg::ID_W-1:0]       req_new_id,
   output logic                            rsp_strobe,
   output logic [suis_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_was_new,
   output logic [suis_pkg::POS_W-1:0]      rsp_position,
   output logic [suis_pkg::COUNT_W-1:0]    rsp_entry_count
);

   suis_pkg::state_type          state_ff;
   suis_pkg::state_type          state_in;
   logic [suis_pkg::ID_W-1:0]    key_ff;
   logic [suis_pkg::CNT_W-1:0]   count_ff;
   logic [suis_pkg::CNT_W-1:0]   count_in;
   suis_pkg::cell_ctrl_type      ctrl;
   suis_pkg::chain_flags_type    flags;
   logic                         accept;
   logic                         key_zero;
   logic                         full;
   logic                         do_insert;

   assign accept = start && (state_ff == suis_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         suis_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = suis_pkg::ST_COMPARE;
            end
         end
         suis_pkg::ST_COMPARE: begin
            state_in = suis_pkg::ST_UPDATE;
         end
         suis_pkg::ST_UPDATE: begin
            state_in = suis_pkg::ST_IDLE;
         end
         default: begin
            state_in = suis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= suis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The key is held for the whole item.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_new_id;
      end
   end

   // Insert decision from the cell flags.
   assign key_zero = (key_ff == '0);
   assign full = (count_ff == suis_pkg::CNT_W'(suis_pkg::CAPACITY));
   assign do_insert = (state_ff == suis_pkg::ST_UPDATE) && !key_zero && !flags.found && !full;

   // Controller outputs.
   always_comb begin
      busy = 1'b1;
      rsp_strobe = 1'b0;
      ctrl.cmp_en = 1'b0;
      ctrl.ins_en = 1'b0;
      ctrl.key = key_ff;
      unique case (state_ff)
         suis_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         suis_pkg::ST_COMPARE: begin
            ctrl.cmp_en = 1'b1;
         end
         suis_pkg::ST_UPDATE: begin
            ctrl.ins_en = do_insert;
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   suis_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .count (count_ff),
      .flags (flags)
   );

   // Entry count.
   assign count_in = do_insert ? count_ff + suis_pkg::CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result fields.
   always_comb begin
      if (key_zero) begin
         rsp_status = suis_pkg::STATUS_ZERO;
         rsp_position = '0;
      end else if (!flags.found && full) begin
         rsp_status = suis_pkg::STATUS_FULL;
         rsp_position = '0;
      end else begin
         rsp_status = suis_pkg::STATUS_OK;
         rsp_position = suis_pkg::POS_W'(flags.pos);
      end
      rsp_was_new = do_insert;
      rsp_entry_count = suis_pkg::COUNT_W'(count_in);
   end

   // The count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= suis_pkg::CNT_W'(suis_pkg::CAPACITY))
      else $error("entry count above capacity");

   // An accepted item yields a result once the controller has passed through the compare state into the update state.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("missing result after transfer");

   // A new insert raises the count by exactly one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_was_new |=> count_ff == $past(count_ff) + suis_pkg::CNT_W'(1))
      else $error("count not advanced on insert");

   // A refused or rejected item never reports an insert.
   a_refuse_no_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == suis_pkg::STATUS_ZERO ||
                     rsp_status == suis_pkg::STATUS_FULL) |-> !rsp_was_new)
      else $error("insert reported on refused item");

endmodule

// ===== rtl/suis_cell.sv =====
// One storage cell of the sorted identifier chain.
// Holds one entry, compares it against the broadcast key and shifts up on insert.
// Depends on suis_pkg.
module suis_cell (
   input  logic                     clock,
   input  suis_pkg::cell_ctrl_type  ctrl,
   input  logic                     occupied,
   input  logic [suis_pkg::ID_W-1:0] below_entry,
   input  logic                     below_lt,
   output logic [suis_pkg::ID_W-1:0] entry,
   output logic                     lt,
   output logic                     eq
);

   logic [suis_pkg::ID_W-1:0] entry_ff;
   logic                      lt_ff;
   logic                      eq_ff;

   // Compare flags are captured once per item; an unoccupied slot captures both flags low.
   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         lt_ff <= occupied & (entry_ff < ctrl.key);
         eq_ff <= occupied & (entry_ff == ctrl.key);
      end
   end

   // On insert, a cell above the insertion point takes its lower neighbor,
   // and the cell right at the insertion point takes the key.
   always_ff @(posedge clock) begin
      if (ctrl.ins_en && !lt_ff) begin
         entry_ff <= below_lt ? ctrl.key : below_entry;
      end
   end

   assign entry = entry_ff;
   assign lt = lt_ff;
   assign eq = eq_ff;

endmodule

// ===== rtl/suis_chain.sv =====
// Row of identifier cells with the flag encoders that summarize them.
// Produces the match flag and the sorted index for the current key.
// Depends on suis_pkg and suis_cell.
module suis_chain (
   input  logic                          clock,
   input  suis_pkg::cell_ctrl_type       ctrl,
   input  logic [suis_pkg::CNT_W-1:0]    count,
   output suis_pkg::chain_flags_type     flags
);

   logic [suis_pkg::ID_W-1:0]     entries [suis_pkg::CAPACITY];
   logic [suis_pkg::CAPACITY-1:0] lt;
   logic [suis_pkg::CAPACITY-1:0] eq;
   logic [suis_pkg::CAPACITY-1:0] ins_oh;

   // The cells; each one hands its entry and compare flag to the one above.
   for (genvar i = 0; i < suis_pkg::CAPACITY; i++) begin : g_cell
      logic                      occ;
      logic [suis_pkg::ID_W-1:0] below_entry;
      logic                      below_lt;

      assign occ = suis_pkg::CNT_W'(i) < count;

      if (i == 0) begin : g_first
         assign below_entry = ctrl.key;
         assign below_lt = 1'b1;
         assign ins_oh[i] = !lt[i];
      end else begin : g_rest
         assign below_entry = entries[i-1];
         assign below_lt = lt[i-1];
         assign ins_oh[i] = lt[i-1] & !lt[i];
      end

      suis_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .below_entry (below_entry),
         .below_lt    (below_lt),
         .entry       (entries[i]),
         .lt          (lt[i]),
         .eq          (eq[i])
      );
   end

   // The less-than flags form a thermometer, so the insertion point and the
   // match are each at most one-hot; encode them into an index.
   always_comb begin
      logic [suis_pkg::IDX_W-1:0] eq_idx;
      logic [suis_pkg::IDX_W-1:0] ins_idx;
      eq_idx = '0;
      ins_idx = '0;
      for (int i = 0; i < suis_pkg::CAPACITY; i++) begin
         if (eq[i]) begin
            eq_idx = eq_idx | suis_pkg::IDX_W'(i);
         end
         if (ins_oh[i]) begin
            ins_idx = ins_idx | suis_pkg::IDX_W'(i);
         end
      end
      flags.found = |eq;
      flags.pos = (|eq) ? eq_idx : ins_idx;
   end

endmodule
